[design/ufb_pkg.sv]
// Package with the types, constants and helper functions of the UDP frame builder.
package ufb_pkg;

  localparam int PAYLOAD_BYTES_DEF = 64;
  localparam int QUEUE_DEPTH       = 16;

  // Configuration register indexes (byte address divided by eight).
  localparam logic [2:0] REG_DEST_MAC    = 3'd0;
  localparam logic [2:0] REG_SOURCE_MAC  = 3'd1;
  localparam logic [2:0] REG_SOURCE_IP   = 3'd2;
  localparam logic [2:0] REG_DEST_IP     = 3'd3;
  localparam logic [2:0] REG_SOURCE_PORT = 3'd4;
  localparam logic [2:0] REG_DEST_PORT   = 3'd5;

  localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT      = 32'hFFFFFFFF;
  localparam logic [31:0] IDLE_WORD     = 32'h00000AAA;
  localparam logic [7:0]  PREAMBLE_BYTE = 8'h55;
  localparam logic [7:0]  SFD_BYTE      = 8'hD5;
  localparam logic [15:0] ETHERTYPE_IP  = 16'h0800;
  localparam logic [7:0]  IP_VER_IHL    = 8'h45;
  localparam logic [7:0]  IP_TTL        = 8'h80;
  localparam logic [7:0]  IP_PROTO_UDP  = 8'h11;
  localparam logic [15:0] CK_FIXED_A    = 16'h4500;
  localparam logic [15:0] CK_FIXED_B    = 16'h8011;
  localparam logic [3:0]  NIB_ONE       = 4'h9;
  localparam logic [3:0]  NIB_ZERO      = 4'h6;

  typedef struct packed {
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
  } cfg_t;

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } qhead_t;

  function automatic logic [31:0] manchester(input logic [7:0] b);
    logic [31:0] w;
    w = '0;
    for (int k = 0; k < 8; k++) begin
      w[4*k +: 4] = b[k] ? NIB_ONE : NIB_ZERO;
    end
    return w;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[design/ufb_if.sv]
// Valid/ready channel interfaces for payload bytes and code words.
interface ufb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;

  modport source (output valid, output payload_byte, input ready);
  modport sink (input valid, input payload_byte, output ready);
endinterface

interface ufb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] code_word;
  logic        last_word;

  modport source (output valid, output code_word, output last_word, input ready);
  modport sink (input valid, input code_word, input last_word, output ready);
endinterface

[design/ufb_queue.sv]
// Small first-in first-out queue of tagged payload bytes between front and back.
module ufb_queue #(
  parameter int Depth = ufb_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ufb_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output ufb_pkg::qhead_t head
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  ufb_pkg::entry_t mem_r [Depth];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]     count_r, count_nxt;

  assign full        = (count_r == (AW+1)'(Depth));
  assign head.valid  = (count_r != '0);
  assign head.entry  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[design/ufb_front.sv]
// Front end: takes payload bytes, marks the last byte of each frame and queues them.
module ufb_front #(
  parameter int PAYLOAD_BYTES = ufb_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  ufb_in_if.sink          in_ch,
  input  logic            pop,
  output ufb_pkg::qhead_t head
);

  localparam int PW = $clog2(PAYLOAD_BYTES + 1);

  logic [PW-1:0]   pos_r, pos_nxt;
  logic            full;
  logic            accept;
  logic            is_last;
  ufb_pkg::entry_t push_data;

  assign in_ch.ready    = !full;
  assign accept         = in_ch.valid && !full;
  assign is_last        = (pos_r == PW'(PAYLOAD_BYTES - 1));
  assign push_data.last = is_last;
  assign push_data.data = in_ch.payload_byte;

  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      pos_nxt = is_last ? '0 : pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  ufb_queue #(
    .Depth(ufb_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_data(push_data),
    .full     (full),
    .pop      (pop),
    .head     (head)
  );

endmodule

[design/ufb_back.sv]
// Back end: sequences header, payload, FCS and idle words into the output register.
module ufb_back #(
  parameter int PAYLOAD_BYTES = ufb_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ufb_pkg::cfg_t   cfg,
  input  ufb_pkg::qhead_t head,
  output logic            pop,
  ufb_out_if.source       out_ch
);

  localparam logic [2:0] ST_SOF   = 3'd0;
  localparam logic [2:0] ST_HDR   = 3'd1;
  localparam logic [2:0] ST_BODY  = 3'd2;
  localparam logic [2:0] ST_FCS   = 3'd3;
  localparam logic [2:0] ST_IDLEW = 3'd4;

  localparam logic [5:0]  HDR_LAST_WORD = 6'd49;
  localparam logic [5:0]  SFD_WORD      = 6'd7;
  localparam logic [15:0] UDP_LEN       = 16'(8 + PAYLOAD_BYTES);
  localparam logic [15:0] IP_TOTAL      = 16'(28 + PAYLOAD_BYTES);

  logic [2:0]  st_r, st_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [15:0] id_r, id_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [18:0] ck_sum_r;
  logic [15:0] ck_r;
  logic [16:0] ck_fold;
  logic [15:0] ck_fold2;
  logic        out_valid_r;
  logic [31:0] out_word_r;
  logic        out_last_r;

  logic        can_load;
  logic        load;
  logic        is_idle;
  logic [7:0]  tx_byte;
  logic [7:0]  hdr_byte;
  logic [5:0]  hidx;
  logic [31:0] fcs;
  logic [31:0] word;

  assign can_load = !out_valid_r || out_ch.ready;
  assign hidx     = cnt_r - SFD_WORD - 6'd1;
  assign fcs      = ~crc_r;

  // Ethernet, IPv4 and UDP header bytes after the SFD, in transmit order.
  always_comb begin
    case (hidx)
      6'd0:  hdr_byte = cfg.dest_mac[47:40];
      6'd1:  hdr_byte = cfg.dest_mac[39:32];
      6'd2:  hdr_byte = cfg.dest_mac[31:24];
      6'd3:  hdr_byte = cfg.dest_mac[23:16];
      6'd4:  hdr_byte = cfg.dest_mac[15:8];
      6'd5:  hdr_byte = cfg.dest_mac[7:0];
      6'd6:  hdr_byte = cfg.source_mac[47:40];
      6'd7:  hdr_byte = cfg.source_mac[39:32];
      6'd8:  hdr_byte = cfg.source_mac[31:24];
      6'd9:  hdr_byte = cfg.source_mac[23:16];
      6'd10: hdr_byte = cfg.source_mac[15:8];
      6'd11: hdr_byte = cfg.source_mac[7:0];
      6'd12: hdr_byte = ufb_pkg::ETHERTYPE_IP[15:8];
      6'd13: hdr_byte = ufb_pkg::ETHERTYPE_IP[7:0];
      6'd14: hdr_byte = ufb_pkg::IP_VER_IHL;
      6'd16: hdr_byte = IP_TOTAL[15:8];
      6'd17: hdr_byte = IP_TOTAL[7:0];
      6'd18: hdr_byte = id_r[15:8];
      6'd19: hdr_byte = id_r[7:0];
      6'd22: hdr_byte = ufb_pkg::IP_TTL;
      6'd23: hdr_byte = ufb_pkg::IP_PROTO_UDP;
      6'd24: hdr_byte = ck_r[15:8];
      6'd25: hdr_byte = ck_r[7:0];
      6'd26: hdr_byte = cfg.source_ip[31:24];
      6'd27: hdr_byte = cfg.source_ip[23:16];
      6'd28: hdr_byte = cfg.source_ip[15:8];
      6'd29: hdr_byte = cfg.source_ip[7:0];
      6'd30: hdr_byte = cfg.dest_ip[31:24];
      6'd31: hdr_byte = cfg.dest_ip[23:16];
      6'd32: hdr_byte = cfg.dest_ip[15:8];
      6'd33: hdr_byte = cfg.dest_ip[7:0];
      6'd34: hdr_byte = cfg.source_port[15:8];
      6'd35: hdr_byte = cfg.source_port[7:0];
      6'd36: hdr_byte = cfg.dest_port[15:8];
      6'd37: hdr_byte = cfg.dest_port[7:0];
      6'd38: hdr_byte = UDP_LEN[15:8];
      6'd39: hdr_byte = UDP_LEN[7:0];
      default: hdr_byte = 8'h00;
    endcase
  end

  // The checksum passes through the ck_sum_r and ck_r registers after the identifier
  // changes, and settles long before its bytes are reached in the header.
  assign ck_fold  = 17'(ck_sum_r[15:0]) + 17'(ck_sum_r[18:16]);
  assign ck_fold2 = ck_fold[15:0] + 16'(ck_fold[16]);

  always_ff @(posedge clk) begin
    ck_sum_r <= 19'(ufb_pkg::CK_FIXED_A) + 19'(IP_TOTAL) + 19'(id_r)
              + 19'(ufb_pkg::CK_FIXED_B)
              + 19'(cfg.source_ip[31:16]) + 19'(cfg.source_ip[15:0])
              + 19'(cfg.dest_ip[31:16]) + 19'(cfg.dest_ip[15:0]);
    ck_r     <= ~ck_fold2;
  end

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    id_nxt  = id_r;
    crc_nxt = crc_r;
    load    = 1'b0;
    is_idle = 1'b0;
    pop     = 1'b0;
    tx_byte = ufb_pkg::PREAMBLE_BYTE;
    case (st_r)
      ST_SOF: begin
        if (head.valid && can_load) begin
          load    = 1'b1;
          cnt_nxt = 6'd1;
          st_nxt  = ST_HDR;
          id_nxt  = id_r + 16'd1;
          crc_nxt = ufb_pkg::CRC_INIT;
        end
      end
      ST_HDR: begin
        if (can_load) begin
          load = 1'b1;
          if (cnt_r < SFD_WORD) begin
            tx_byte = ufb_pkg::PREAMBLE_BYTE;
          end else if (cnt_r == SFD_WORD) begin
            tx_byte = ufb_pkg::SFD_BYTE;
          end else begin
            tx_byte = hdr_byte;
            crc_nxt = ufb_pkg::crc_byte(crc_r, hdr_byte);
          end
          if (cnt_r == HDR_LAST_WORD) begin
            st_nxt = ST_BODY;
          end else begin
            cnt_nxt = cnt_r + 6'd1;
          end
        end
      end
      ST_BODY: begin
        if (head.valid && can_load) begin
          load    = 1'b1;
          pop     = 1'b1;
          tx_byte = head.entry.data;
          crc_nxt = ufb_pkg::crc_byte(crc_r, head.entry.data);
          if (head.entry.last) begin
            st_nxt  = ST_FCS;
            cnt_nxt = '0;
          end
        end
      end
      ST_FCS: begin
        if (can_load) begin
          load    = 1'b1;
          tx_byte = 8'(fcs >> {cnt_r[1:0], 3'b000});
          if (cnt_r[1:0] == 2'd3) begin
            st_nxt = ST_IDLEW;
          end else begin
            cnt_nxt = cnt_r + 6'd1;
          end
        end
      end
      ST_IDLEW: begin
        if (can_load) begin
          load    = 1'b1;
          is_idle = 1'b1;
          st_nxt  = ST_SOF;
        end
      end
      default: begin
        st_nxt = ST_SOF;
      end
    endcase
  end

  assign word = is_idle ? ufb_pkg::IDLE_WORD : ufb_pkg::manchester(tx_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_SOF;
      cnt_r       <= '0;
      id_r        <= '0;
      crc_r       <= ufb_pkg::CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      id_r  <= id_nxt;
      crc_r <= crc_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word_r <= word;
      out_last_r <= is_idle;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.code_word = out_word_r;
  assign out_ch.last_word = out_last_r;

  // A payload byte leaves the queue only once the header has gone out.
  a_pop_in_body: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (st_r == ST_BODY))
    else $error("payload popped outside the frame body");

  // The header counter never runs past the last header word.
  a_hdr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_HDR) |-> (cnt_r <= HDR_LAST_WORD))
    else $error("header counter overran");

  // After the idle word the sequencer waits for a new frame.
  a_idle_then_sof: assert property (@(posedge clk) disable iff (!rst_n)
    (load && is_idle) |=> (st_r == ST_SOF))
    else $error("no return to start of frame after idle word");

  // A new word is only loaded when the output register is free or draining.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_word_r)))
    else $error("stalled code word overwritten");

  // The identifier advances by one exactly when a frame starts.
  a_id_step: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SOF && st_nxt == ST_HDR) |=> (id_r == $past(id_r) + 16'd1))
    else $error("packet identifier did not advance");

endmodule

[design/udp_frame_builder_manchester.sv]
// Top level of the UDP frame builder: configuration registers, front and back ends.
//
//  Channel   Direction  Request carries                  Accepted when
//  in_ch     in         payload_byte (8 bits)            valid & ready
//  out_ch    out        code_word (32), last_word (1)    valid & ready
//  APB       in         64-bit register write / read     psel & penable & pwrite
//
// The output produces one code word per cycle while out_ch.ready is high and, in
// the payload, while the queue holds a byte; every word of the frame comes from
// the single back-end word sequencer. Input bytes are taken one per cycle while
// the 16-entry queue has room, and wait during the 50-word header burst once it
// fills. Reset is synchronous and active low; it clears the configuration
// registers to zero, the identifier to zero and the CRC register to all ones.
// A stall on the output holds its word in the output register without blocking
// the input until the queue is full.
module udp_frame_builder_manchester #(
  parameter int PAYLOAD_BYTES = ufb_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ufb_in_if.sink      in_ch,
  ufb_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  ufb_pkg::cfg_t   cfg_r;
  ufb_pkg::qhead_t head;
  logic            pop;
  logic            cfg_wr;
  logic [2:0]      cfg_idx;

  // Registers sit at eight-byte strides; the low address bits are ignored.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        ufb_pkg::REG_DEST_MAC:    cfg_r.dest_mac    <= pwdata[47:0];
        ufb_pkg::REG_SOURCE_MAC:  cfg_r.source_mac  <= pwdata[47:0];
        ufb_pkg::REG_SOURCE_IP:   cfg_r.source_ip   <= pwdata[31:0];
        ufb_pkg::REG_DEST_IP:     cfg_r.dest_ip     <= pwdata[31:0];
        ufb_pkg::REG_SOURCE_PORT: cfg_r.source_port <= pwdata[15:0];
        ufb_pkg::REG_DEST_PORT:   cfg_r.dest_port   <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // Reads return the register zero-extended; unused addresses read as zero.
  always_comb begin
    case (cfg_idx)
      ufb_pkg::REG_DEST_MAC:    prdata = 64'(cfg_r.dest_mac);
      ufb_pkg::REG_SOURCE_MAC:  prdata = 64'(cfg_r.source_mac);
      ufb_pkg::REG_SOURCE_IP:   prdata = 64'(cfg_r.source_ip);
      ufb_pkg::REG_DEST_IP:     prdata = 64'(cfg_r.dest_ip);
      ufb_pkg::REG_SOURCE_PORT: prdata = 64'(cfg_r.source_port);
      ufb_pkg::REG_DEST_PORT:   prdata = 64'(cfg_r.dest_port);
      default:                  prdata = '0;
    endcase
  end

  // The front end tags each byte with its end-of-frame flag and queues it.
  ufb_front #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_front (
    .clk  (clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .pop  (pop),
    .head (head)
  );

  // The back end builds the frame around the queued bytes, one word a cycle unless out_ch stalls or the queue runs dry.
  ufb_back #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .head  (head),
    .pop   (pop),
    .out_ch(out_ch)
  );

endmodule
